// File: rtl/qrt_pkg.sv
// ----------------------------------------------------------------------------
// qrt_pkg: shared types and constants of the quality run trimmer
// transfer payloads, encoding codes, register indexes and the solexa table
// ----------------------------------------------------------------------------
package qrt_pkg;

  // read buffer length, positions at or past it only raise the too-long and bad-character flags
  localparam int unsigned MaxReadLength = 512;

  // output field widths
  localparam int unsigned KeepStartW  = 9;
  localparam int unsigned KeepLengthW = 10;
  localparam int unsigned PhredW      = 7;

  // configuration register indexes
  localparam logic CfgIdxEncoding   = 1'b0;
  localparam logic CfgIdxMinQuality = 1'b1;

  localparam logic [6:0] MinQualityReset = 7'd70;

  // input character encodings
  typedef enum logic [1:0] {
    EncPhred33 = 2'd0,
    EncPhred64 = 2'd1,
    EncSolexa  = 2'd2,
    EncUnused  = 2'd3
  } encoding_e;

  // legal character ranges
  localparam logic [7:0] Phred33Lo = 8'd33;   // '!'
  localparam logic [7:0] Phred33Hi = 8'd73;   // 'I'
  localparam logic [7:0] Phred64Lo = 8'd64;   // '@'
  localparam logic [7:0] Phred64Hi = 8'd104;  // 'h'
  localparam logic [7:0] SolexaLo  = 8'd59;   // ';'
  localparam logic [7:0] Phred64Offset = 8'd31;
  localparam logic [7:0] SolexaIdxBase = 8'd54;
  localparam logic [7:0] SolexaTableN  = 8'd20;
  localparam logic [7:0] Phred33Base   = 8'd33;

  typedef struct packed {
    logic [7:0] quality_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [KeepStartW-1:0]  keep_start;
    logic [KeepLengthW-1:0] keep_length;
    logic                   bad_char_seen;
    logic                   read_too_long;
  } out_item_t;

  typedef struct packed {
    logic              ok;
    logic [PhredW-1:0] phred;
  } conv_t;

  // phred value for solexa score + 10 below twenty
  function automatic logic [3:0] solexa_low(input logic [4:0] idx);
    logic [3:0] v;
    case (idx)
      5'd0:                         v = 4'd0;
      5'd1, 5'd2, 5'd3, 5'd4,
      5'd5, 5'd6:                   v = 4'd1;
      5'd7, 5'd8:                   v = 4'd2;
      5'd9, 5'd10:                  v = 4'd3;
      5'd11, 5'd12:                 v = 4'd4;
      5'd13, 5'd14:                 v = 4'd5;
      5'd15:                        v = 4'd6;
      5'd16:                        v = 4'd7;
      5'd17:                        v = 4'd8;
      5'd18:                        v = 4'd9;
      5'd19:                        v = 4'd10;
      default:                      v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/quality_run_trimmer.sv
// ----------------------------------------------------------------------------
// quality_run_trimmer: longest good-quality run finder for sequencing reads
// converts each quality character and reports the longest qualifying run
// ----------------------------------------------------------------------------
// One quality character is taken per transfer, one per clock cycle. The
// conversion, threshold compare and run bookkeeping are combinational
// logic feeding the run registers, so characters stream at full rate. When a
// character marked last_char is taken, the result (start and length of the
// longest run, first run on a tie, plus the bad-character and too-long flags)
// appears in the output register on the next cycle and the per-read state is
// cleared, so the next read may start right behind it. The input stalls only
// when a last character arrives while the previous result has not yet been
// taken; ordinary characters are taken regardless. Characters beyond the
// read buffer (qrt_pkg::MaxReadLength) set read_too_long and are otherwise
// only range-checked. Configuration is written through a plain write port; the
// user must do so only while no read is open, which the block does not enforce.
module quality_run_trimmer (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  // character input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qrt_pkg::in_item_t   in_data_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qrt_pkg::out_item_t  out_data_o
);

  // position saturates at the buffer length, a run never starts there
  localparam int unsigned PosW   = $clog2(qrt_pkg::MaxReadLength + 1);
  localparam int unsigned StartW = $clog2(qrt_pkg::MaxReadLength);
  localparam logic [PosW-1:0] PosMax = PosW'(qrt_pkg::MaxReadLength);

  // configuration registers
  logic [1:0] encoding_q;
  logic [6:0] min_qual_q;

  // per-read state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [StartW-1:0] run_start_q, run_start_d;
  logic [PosW-1:0]   run_len_q, run_len_d;
  logic [StartW-1:0] best_start_q, best_start_d;
  logic [PosW-1:0]   best_len_q, best_len_d;
  logic              bad_q, bad_d;
  logic              ovf_q, ovf_d;

  // output register
  logic               out_valid_q;
  qrt_pkg::out_item_t out_data_q;

  qrt_pkg::conv_t conv;
  logic           in_fire;
  logic           good;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q <= qrt_pkg::EncPhred33;
      min_qual_q <= qrt_pkg::MinQualityReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        qrt_pkg::CfgIdxEncoding:   encoding_q <= cfg_data_i[1:0];
        qrt_pkg::CfgIdxMinQuality: min_qual_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qrt_convert u_convert (
    .encoding_i (encoding_q),
    .char_i     (in_data_i.quality_char),
    .conv_o     (conv)
  );

  // only a result-producing transfer needs room in the output register
  assign in_ready_o = !out_valid_q || out_ready_i || !in_data_i.last_char;
  assign in_fire    = in_valid_i && in_ready_o;

  assign good = conv.ok && (conv.phred >= min_qual_q);

  // run bookkeeping for the incoming character
  always_comb begin
    pos_d        = pos_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    bad_d        = bad_q || !conv.ok;
    ovf_d        = ovf_q;
    if (pos_q == PosMax) begin
      // past the buffer: the run is frozen
      ovf_d = 1'b1;
    end else begin
      if (good) begin
        if (run_len_q == '0) begin
          run_start_d = pos_q[StartW-1:0];
        end
        run_len_d = run_len_q + PosW'(1);
        // strict compare keeps the earlier run on a tie
        if (run_len_d > best_len_q) begin
          best_len_d   = run_len_d;
          best_start_d = run_start_d;
        end
      end else begin
        run_len_d = '0;
      end
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      run_start_q  <= '0;
      run_len_q    <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
    end else if (in_fire) begin
      if (in_data_i.last_char) begin
        // read closed: start the next one clean
        pos_q        <= '0;
        run_start_q  <= '0;
        run_len_q    <= '0;
        best_start_q <= '0;
        best_len_q   <= '0;
        bad_q        <= 1'b0;
        ovf_q        <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        run_start_q  <= run_start_d;
        run_len_q    <= run_len_d;
        best_start_q <= best_start_d;
        best_len_q   <= best_len_d;
        bad_q        <= bad_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_data_i.last_char) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_char) begin
      out_data_q.keep_start    <= qrt_pkg::KeepStartW'(best_start_d);
      out_data_q.keep_length   <= qrt_pkg::KeepLengthW'(best_len_d);
      out_data_q.bad_char_seen <= bad_d;
      out_data_q.read_too_long <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the current run never beats the best one
  a_run_le_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_len_q <= best_len_q)
    else $error("current run longer than best run");

  // best run fits inside the positions seen so far
  a_best_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_len_q <= pos_q) && (pos_q <= PosMax))
    else $error("best run or position out of bounds");

  // a closing character always yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_char) |=> out_valid_q)
    else $error("no result after last character");

  // a closing character clears the per-read state
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_char) |=> (pos_q == '0 && best_len_q == '0 && !bad_q && !ovf_q))
    else $error("per-read state not cleared");

  // overflow only after the position has saturated
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (pos_q == PosMax))
    else $error("overflow flag without saturated position");

endmodule

// File: rtl/qrt_convert.sv
// ----------------------------------------------------------------------------
// qrt_convert: quality character conversion
// maps a raw character to phred+33 under the selected encoding, flags range
// ----------------------------------------------------------------------------
module qrt_convert (
  input  logic [1:0]     encoding_i,
  input  logic [7:0]     char_i,
  output qrt_pkg::conv_t conv_o
);

  logic [7:0] sol_idx;
  logic [7:0] sol_phred;
  logic [7:0] phred;
  logic       ok;

  assign sol_idx   = char_i - qrt_pkg::SolexaIdxBase;
  assign sol_phred = (sol_idx < qrt_pkg::SolexaTableN)
                   ? 8'(qrt_pkg::solexa_low(sol_idx[4:0])) + qrt_pkg::Phred33Base
                   : char_i - qrt_pkg::Phred64Offset;

  always_comb begin
    ok    = 1'b0;
    phred = char_i;
    unique case (qrt_pkg::encoding_e'(encoding_i))
      qrt_pkg::EncPhred33: begin
        ok    = (char_i >= qrt_pkg::Phred33Lo) && (char_i <= qrt_pkg::Phred33Hi);
        phred = char_i;
      end
      qrt_pkg::EncPhred64: begin
        ok    = (char_i >= qrt_pkg::Phred64Lo) && (char_i <= qrt_pkg::Phred64Hi);
        phred = char_i - qrt_pkg::Phred64Offset;
      end
      qrt_pkg::EncSolexa: begin
        ok    = (char_i >= qrt_pkg::SolexaLo) && (char_i <= qrt_pkg::Phred64Hi);
        phred = sol_phred;
      end
      default: begin
        ok    = 1'b0;
        phred = char_i;
      end
    endcase
  end

  // out of range characters carry a dont-care value, gated by ok downstream
  assign conv_o.ok    = ok;
  assign conv_o.phred = phred[qrt_pkg::PhredW-1:0];

endmodule

// File: test/trim_result_checker.sv
// ----------------------------------------------------------------------------
// trim_result_checker: scoreboard for the quality run trimmer
// tracks the longest qualifying run of each read from the observed transfers
// and compares every result transfer with the oldest predicted trim
// ----------------------------------------------------------------------------
module trim_result_checker #(
  parameter int unsigned MaxReadLen = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  qrt_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  qrt_pkg::out_item_t out_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import qrt_pkg::*;

  encoding_e   enc_q;
  logic [6:0]  min_qual_q;
  logic [9:0]  pos_q;
  logic [8:0]  run_start_q;
  logic [9:0]  run_len_q;
  logic [8:0]  best_start_q;
  logic [9:0]  best_len_q;
  logic        bad_q;
  logic        ovf_q;
  int unsigned mismatches;

  out_item_t   expected_trims[$];

  // phred value for a solexa score offset by ten, below twenty
  function automatic logic [7:0] solexa_low_phred(input logic [4:0] score10);
    case (score10)
      5'd0:                                  return 8'd0;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6:    return 8'd1;
      5'd7, 5'd8:                            return 8'd2;
      5'd9, 5'd10:                           return 8'd3;
      5'd11, 5'd12:                          return 8'd4;
      5'd13, 5'd14:                          return 8'd5;
      5'd15:                                 return 8'd6;
      5'd16:                                 return 8'd7;
      5'd17:                                 return 8'd8;
      5'd18:                                 return 8'd9;
      default:                               return 8'd10;
    endcase
  endfunction

  // phred+33 value of a raw character, 0 when out of range
  function automatic logic phred_of(input logic [7:0] c, input encoding_e enc,
                                    output logic [7:0] q);
    logic [7:0] idx;
    q   = '0;
    idx = c - 8'd54;
    case (enc)
      EncPhred33: begin
        if (c < 8'd33 || c > 8'd73) return 1'b0;
        q = c;
      end
      EncPhred64: begin
        if (c < 8'd64 || c > 8'd104) return 1'b0;
        q = c - 8'd31;
      end
      EncSolexa: begin
        if (c < 8'd59 || c > 8'd104) return 1'b0;
        q = ((idx < 8'd20) ? solexa_low_phred(idx[4:0]) : idx - 8'd10) + 8'd33;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic clear_read();
    pos_q        = '0;
    run_start_q  = '0;
    run_len_q    = '0;
    best_start_q = '0;
    best_len_q   = '0;
    bad_q        = 1'b0;
    ovf_q        = 1'b0;
  endtask

  task automatic track_char(input in_item_t item);
    logic       ok;
    logic [7:0] q;
    out_item_t  trim;
    ok = phred_of(item.quality_char, enc_q, q);
    if (!ok) bad_q = 1'b1;
    if (pos_q >= MaxReadLen) begin
      // past the buffer: only flags change
      ovf_q = 1'b1;
    end else begin
      if (ok && q >= {1'b0, min_qual_q}) begin
        if (run_len_q == '0) run_start_q = pos_q[8:0];
        run_len_q = run_len_q + 10'd1;
        // strict compare keeps the earlier run on a tie
        if (run_len_q > best_len_q) begin
          best_len_q   = run_len_q;
          best_start_q = run_start_q;
        end
      end else begin
        run_len_q = '0;
      end
      pos_q = pos_q + 10'd1;
    end
    if (item.last_char) begin
      trim.keep_start    = best_start_q;
      trim.keep_length   = best_len_q;
      trim.bad_char_seen = bad_q;
      trim.read_too_long = ovf_q;
      expected_trims.push_back(trim);
      clear_read();
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      enc_q      = EncPhred33;
      min_qual_q = MinQualityReset;
      clear_read();
      expected_trims.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgIdxEncoding:   enc_q = encoding_e'(cfg_data_i[1:0]);
          CfgIdxMinQuality: min_qual_q = cfg_data_i;
          default:          ;
        endcase
      end
      // results first: a result never stems from the same edge's input
      if (out_valid_i && out_ready_i) begin
        if (expected_trims.size() == 0) begin
          $display("%0t unexpected result: start %0d length %0d bad %0b long %0b",
                   $time, out_data_i.keep_start, out_data_i.keep_length,
                   out_data_i.bad_char_seen, out_data_i.read_too_long);
          mismatches++;
        end else begin
          want = expected_trims.pop_front();
          check_field("keep_start", 16'(want.keep_start), 16'(out_data_i.keep_start));
          check_field("keep_length", 16'(want.keep_length), 16'(out_data_i.keep_length));
          check_field("bad_char_seen", 16'(want.bad_char_seen),
                      16'(out_data_i.bad_char_seen));
          check_field("read_too_long", 16'(want.read_too_long),
                      16'(out_data_i.read_too_long));
        end
      end
      if (in_valid_i && in_ready_i) track_char(in_data_i);
      pending_o    <= expected_trims.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench of the quality run trimmer
// drives directed and random reads under all encodings and varied thresholds, with
// bursty input, a stalling result sink and one long sink hold-off; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
  import qrt_pkg::*;

  localparam int unsigned MaxReadLen  = MaxReadLength;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TargetChars = 1000;
  localparam int unsigned HoldCycles  = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles      = 0;
  int unsigned chars_sent  = 0;
  int unsigned burst_left  = 0;
  logic        hold_armed  = 1'b0;
  logic        good_run    = 1'b1;

  // configuration as last written, used to aim the random characters
  encoding_e   cur_enc = EncPhred33;
  logic [6:0]  cur_thr = MinQualityReset;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quality_run_trimmer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_item)
  );

  trim_result_checker #(
    .MaxReadLen (MaxReadLen)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // watchdog on a hung handshake or a lost result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one character transfer; valid stays up across a burst
  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned r;
    int unsigned gap;
    if (burst_left == 0) begin
      r   = $urandom_range(0, 9);
      // mostly short gaps, some long ones, now and then none at all
      gap = (r < 5) ? $urandom_range(1, 3) : (r < 8) ? $urandom_range(4, 12) : 0;
      burst_left = (r == 9) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= '{quality_char: ch, last_char: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  // wait until every predicted trim has come back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change with no read open and nothing in flight
  task automatic configure(input encoding_e enc, input logic [6:0] thr);
    drain();
    write_reg(CfgIdxEncoding, {5'b0, enc});
    write_reg(CfgIdxMinQuality, thr);
    cur_enc = enc;
    cur_thr = thr;
  endtask

  // raw character on the good or bad side of the threshold, with some noise
  function automatic logic [7:0] pick_char(input logic good, input int unsigned noise_pct);
    int lo;
    int hi;
    int mid;
    int unsigned r;
    case (cur_enc)
      EncPhred33: begin lo = int'(Phred33Lo); hi = int'(Phred33Hi); end
      EncPhred64: begin lo = int'(Phred64Lo); hi = int'(Phred64Hi); end
      EncSolexa:  begin lo = int'(SolexaLo);  hi = int'(Phred64Hi); end
      default:    begin lo = 0;               hi = 255;             end
    endcase
    // raw character near the threshold once converted
    mid = (cur_enc == EncPhred33) ? int'(cur_thr) : int'(cur_thr) + 31;
    if (mid < lo) mid = lo;
    if (mid > hi) mid = hi;
    r = $urandom_range(0, 99);
    if (r < noise_pct / 2) return 8'($urandom_range(0, 255));
    if (r < noise_pct) begin
      // range edges and just outside them
      case ($urandom_range(0, 3))
        0:       return 8'(lo - 1);
        1:       return 8'(lo);
        2:       return 8'(hi);
        default: return 8'(hi + 1);
      endcase
    end
    return good ? 8'($urandom_range(mid, hi)) : 8'($urandom_range(lo, mid));
  endfunction

  // a whole read; the good/bad state is sticky to form runs
  task automatic send_read(input int unsigned len, input int unsigned flip_pct,
                           input int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < flip_pct) good_run = ~good_run;
      send_char(pick_char(good_run, noise_pct), i == len - 1);
    end
  endtask

  // result sink: stall patterns of its own, one long hold-off when armed
  initial begin : result_sink
    int unsigned mode;
    int unsigned seg_len;
    int unsigned k;
    bit          held;
    held = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 80);
      k       = $urandom_range(2, 5);
      for (int unsigned i = 0; i < seg_len; i++) begin
        if (hold_armed && !held) begin
          // sink goes quiet while the sender keeps offering reads
          held = 1'b1;
          repeat (HoldCycles) begin
            @(posedge clk);
            out_ready <= 1'b0;
          end
        end
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((i % k) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          phase;
    int unsigned base_chars;
    int unsigned reads;
    int unsigned len;
    int unsigned r;
    int unsigned noise;
    encoding_e   enc;
    logic [6:0]  thr;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration: phred+33, threshold 'F'
    send_char("!", 1'b1);                   // single char, nothing qualifies
    send_char("I", 1'b0);                   // two runs of two, first one wins
    send_char("I", 1'b0);
    send_char("!", 1'b0);
    send_char("I", 1'b0);
    send_char("I", 1'b1);
    send_char(8'd0, 1'b0);                  // all-zero and all-one characters
    send_char(8'd255, 1'b0);
    send_char("F", 1'b0);                   // exactly on the threshold
    send_char("E", 1'b0);                   // just below it
    send_char("I", 1'b1);
    send_char(8'd32, 1'b0);                 // just outside the phred+33 range
    send_char(8'd74, 1'b0);
    send_char("I", 1'b1);

    // solexa: range edges and both sides of the table boundary
    configure(EncSolexa, 7'd33);
    send_char(8'd58, 1'b0);
    send_char(";", 1'b0);
    send_char(8'd73, 1'b0);
    send_char(8'd74, 1'b0);
    send_char("h", 1'b0);
    send_char(8'd105, 1'b1);

    // unused encoding with a zero threshold: still nothing in range
    configure(EncUnused, 7'd0);
    send_char("I", 1'b0);
    send_char("h", 1'b1);

    // phred+64 with the top threshold: nothing can reach it
    configure(EncPhred64, 7'd127);
    send_char("@", 1'b0);
    send_char("h", 1'b1);

    // random phases, each with its own encoding and threshold
    base_chars = chars_sent;
    phase      = 0;
    while (phase < 10 || chars_sent - base_chars < TargetChars) begin
      enc = encoding_e'(phase % 4);
      case (phase)
        1:       thr = 7'd0;
        2:       thr = 7'd127;
        3:       thr = 7'd73;
        default: thr = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(38, 72));
      endcase
      configure(enc, thr);
      if (phase == 0) hold_armed <= 1'b1;
      if (phase == 1) begin
        // full-buffer run of maximum length that goes on past the buffer
        len = MaxReadLen + $urandom_range(1, 12);
        for (int unsigned i = 0; i < len; i++) begin
          send_char((i < MaxReadLen) ? pick_char(1'b1, 0) : pick_char(good_run, 40),
                    i == len - 1);
        end
      end
      reads = $urandom_range(2, 6);
      repeat (reads) begin
        r = $urandom_range(0, 99);
        // very short reads while the sink is held off, to fill the block
        if (phase == 0) len = $urandom_range(1, 4);
        else len = (r < 10) ? 1 : (r < 85) ? $urandom_range(2, 24) : $urandom_range(25, 80);
        noise = ($urandom_range(0, 4) == 0) ? 40 : 10;
        send_read(len, 15, noise);
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/qrt_pkg.sv
rtl/qrt_convert.sv
rtl/quality_run_trimmer.sv
test/trim_result_checker.sv
test/tb.sv
